[hdl/pbp_pkg.sv]
// ============================================================================
// pbp_pkg
// Shared types and constants of the perceptron branch predictor.
// ============================================================================
package pbp_pkg;

    localparam int THRESH_W = 11;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 11'd35;

    localparam logic OP_PREDICT = 1'b0;
    localparam logic OP_TRAIN   = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [31:0] branch_pc;
        logic        taken_outcome;
    } in_word_t;

    typedef struct packed {
        logic predict_taken;
        logic weights_updated;
    } out_word_t;

    typedef struct packed {
        logic        op;
        logic [31:0] pc;
        logic        outcome;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } req_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } ctl_t;

endpackage

[hdl/perceptron_branch_predictor.sv]
// Path: row read, sum, then the update step loads the output register and raises out_valid.
// The back end takes one word at a time; the update step waits while the output is stalled.
// The queue holds two words, so input stays open while the back end works, until the queue is full.
// After reset a clearing pass zeroes all 2**TABLE_INDEX_BITS rows of the weight store,
// during which in_stall is high; the threshold resets to 35 and the history to zero.
// ============================================================================
// perceptron_branch_predictor
// Perceptron branch predictor with a queued front end and a trained weight store.
// ============================================================================
module perceptron_branch_predictor #(
    parameter int HISTORY_LENGTH   = 11,
    parameter int TABLE_INDEX_BITS = 13,
    parameter int WEIGHT_BITS      = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  pbp_pkg::in_word_t            in_word,
    output logic                         out_valid,
    input  logic                         out_stall,
    output pbp_pkg::out_word_t           out_word,
    input  logic                         cfg_wr_en,
    input  logic [pbp_pkg::THRESH_W-1:0] cfg_wr_data
);
    import pbp_pkg::*;

    req_t req;
    ctl_t ctl;

    pbp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_word  (in_word),
        .ctl      (ctl),
        .req      (req)
    );

    pbp_back #(
        .HISTORY_LENGTH   (HISTORY_LENGTH),
        .TABLE_INDEX_BITS (TABLE_INDEX_BITS),
        .WEIGHT_BITS      (WEIGHT_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .ctl         (ctl),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_word    (out_word)
    );

endmodule

[hdl/pbp_front.sv]
// ============================================================================
// pbp_front
// Input side: accepts branch words, classifies them as predict or train
// commands, and holds them in a two-entry queue for the back end.
// ============================================================================
module pbp_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  pbp_pkg::in_word_t in_word,
    input  pbp_pkg::ctl_t    ctl,
    output pbp_pkg::req_t    req
);
    import pbp_pkg::*;

    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    cmd_t       q_reg [2];
    cmd_t       new_cmd;
    logic       push;

    assign in_stall = (count_reg == 2'd2) || ctl.clearing;
    assign push     = in_valid && !in_stall;

    always_comb
    begin
        new_cmd.op      = in_word.mode ? OP_TRAIN : OP_PREDICT;
        new_cmd.pc      = in_word.branch_pc;
        new_cmd.outcome = in_word.taken_outcome;
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !ctl.pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && ctl.pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (ctl.pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

    assign req.valid = (count_reg != 2'd0);
    assign req.cmd   = q_reg[rd_ptr_reg];

endmodule

[hdl/pbp_back.sv]
// ============================================================================
// pbp_back
// Execution side: clears the weight store after reset, then reads one row per
// command, forms the perceptron sum, on train commands shifts the history and
// trains the row if needed, and holds the result word in an output register.
// ============================================================================
module pbp_back #(
    parameter int HISTORY_LENGTH   = 11,
    parameter int TABLE_INDEX_BITS = 13,
    parameter int WEIGHT_BITS      = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pbp_pkg::req_t                  req,
    output pbp_pkg::ctl_t                  ctl,
    input  logic                           cfg_wr_en,
    input  logic [pbp_pkg::THRESH_W-1:0]   cfg_wr_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output pbp_pkg::out_word_t             out_word
);
    import pbp_pkg::*;

    localparam int ROW_LEN = HISTORY_LENGTH + 1;
    localparam int ROW_W   = ROW_LEN * WEIGHT_BITS;
    localparam int SUM_W   = WEIGHT_BITS + $clog2(ROW_LEN) + 1;
    localparam int CMP_W   = (SUM_W > THRESH_W) ? SUM_W : THRESH_W;
    localparam int ROWS    = 2 ** TABLE_INDEX_BITS;

    localparam logic [WEIGHT_BITS-1:0] W_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
    localparam logic [WEIGHT_BITS-1:0] W_MIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_SUM   = 2'd2;
    localparam logic [1:0] ST_UPD   = 2'd3;

    logic [1:0]                  state_reg;
    logic [1:0]                  state_next;
    logic [TABLE_INDEX_BITS-1:0] clr_cnt_reg;
    logic [HISTORY_LENGTH-1:0]   history_reg;
    logic [THRESH_W-1:0]         thresh_reg;
    cmd_t                        cmd_reg;
    logic [TABLE_INDEX_BITS-1:0] row_reg;
    logic [ROW_W-1:0]            rd_data_reg;
    logic signed [SUM_W-1:0]     sum_reg;
    logic signed [SUM_W-1:0]     sum_next;
    logic                        out_valid_reg;
    out_word_t                   out_word_reg;

    logic [ROW_W-1:0]            mem [ROWS];
    logic                        mem_we;
    logic [TABLE_INDEX_BITS-1:0] mem_waddr;
    logic [ROW_W-1:0]            mem_wdata;
    logic                        mem_re;
    logic [TABLE_INDEX_BITS-1:0] mem_raddr;

    logic [31:0]                 hist_ext;
    logic [ROW_W-1:0]            new_row;
    logic [SUM_W-1:0]            mag;
    logic                        predict;
    logic                        learn;
    logic                        out_free;
    logic                        finish;
    logic                        hist_we;
    logic                        upd_we;

    function automatic logic [WEIGHT_BITS-1:0] sat_step(
        input logic [WEIGHT_BITS-1:0] w,
        input logic                   up
    );
        if (up)
        begin
            return (w == W_MAX) ? w : w + 1'b1;
        end
        return (w == W_MIN) ? w : w - 1'b1;
    endfunction

    assign hist_ext  = 32'(history_reg);
    assign mem_raddr = req.cmd.pc[TABLE_INDEX_BITS-1:0] ^ hist_ext[TABLE_INDEX_BITS-1:0];
    assign mem_re    = (state_reg == ST_IDLE) && req.valid;

    assign ctl.pop      = mem_re;
    assign ctl.clearing = (state_reg == ST_CLEAR);

    always_comb
    begin
        logic signed [SUM_W-1:0] part [ROW_LEN];
        part[0] = SUM_W'(signed'(rd_data_reg[WEIGHT_BITS-1:0]));
        for (int i = 1; i < ROW_LEN; i++)
        begin
            part[i] = SUM_W'(signed'(rd_data_reg[i*WEIGHT_BITS +: WEIGHT_BITS]));
            if (!history_reg[i-1])
            begin
                part[i] = -part[i];
            end
        end
        for (int s = 1; s < ROW_LEN; s = s * 2)
        begin
            for (int i = 0; i + s < ROW_LEN; i = i + 2 * s)
            begin
                part[i] = part[i] + part[i + s];
            end
        end
        sum_next = part[0];
    end

    always_comb
    begin
        new_row[WEIGHT_BITS-1:0] = sat_step(rd_data_reg[WEIGHT_BITS-1:0], cmd_reg.outcome);
        for (int i = 1; i < ROW_LEN; i++)
        begin
            new_row[i*WEIGHT_BITS +: WEIGHT_BITS] =
                sat_step(rd_data_reg[i*WEIGHT_BITS +: WEIGHT_BITS],
                         cmd_reg.outcome == history_reg[i-1]);
        end
    end

    assign predict  = !sum_reg[SUM_W-1];
    assign mag      = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign learn    = (predict != cmd_reg.outcome) || (CMP_W'(mag) <= CMP_W'(thresh_reg));
    assign out_free = !out_valid_reg || !out_stall;
    assign finish   = (state_reg == ST_UPD) && out_free;
    assign hist_we  = finish && (cmd_reg.op == OP_TRAIN);
    assign upd_we   = hist_we && learn;

    assign mem_we    = ctl.clearing || upd_we;
    assign mem_waddr = ctl.clearing ? clr_cnt_reg : row_reg;
    assign mem_wdata = ctl.clearing ? '0 : new_row;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == {TABLE_INDEX_BITS{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            history_reg   <= '0;
            thresh_reg    <= THRESH_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ctl.clearing)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cfg_wr_en)
            begin
                thresh_reg <= cfg_wr_data;
            end
            if (hist_we)
            begin
                history_reg <= (history_reg << 1) | HISTORY_LENGTH'(cmd_reg.outcome);
            end
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            cmd_reg <= req.cmd;
            row_reg <= mem_raddr;
        end
        if (state_reg == ST_SUM)
        begin
            sum_reg <= sum_next;
        end
        if (finish)
        begin
            out_word_reg.predict_taken   <= predict;
            out_word_reg.weights_updated <= upd_we && (new_row != rd_data_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

`ifndef SYNTHESIS
    a_pop_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pop |-> req.valid)
        else $error("Queue popped while empty.");

    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !out_valid_reg)
        else $error("Result shown during the clearing pass.");

    a_row_write_on_train: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg != ST_CLEAR) |->
            (state_reg == ST_UPD && cmd_reg.op == OP_TRAIN))
        else $error("Weight row written outside a train update.");

    a_history_on_train: assert property (@(posedge clk) disable iff (!rst_n)
        (history_reg != $past(history_reg)) |-> $past(hist_we))
        else $error("History changed without a train word.");
`endif

endmodule
